[hw/rtl/oets_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oets_pkg
// shared types and constants for the odd-even transposition sort unit
// ----------------------------------------------------------------------------
package oets_pkg;

    localparam int unsigned DATA_W = 32;

    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_LOAD  = 2'd1,
        CELL_SORT  = 2'd2,
        CELL_DRAIN = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     phase;
    } cell_ctrl_t;

endpackage

[hw/rtl/odd_even_transposition_sort_unit.sv]
`timescale 1ns / 1ps
// load: one transaction per cycle into the cell row, ready held low after the closing one
// sort: one transposition phase per cycle in the row, as many phases as kept values
// drain: one sorted value per cycle straight from the first cell while m_ready is high
// a new set of n values loads only after the previous set has fully drained
// first result appears in drain, once the closing transaction and all sort phases are done
// aresetn (synchronous, active low) empties the row and returns to load
// ----------------------------------------------------------------------------
// odd_even_transposition_sort_unit
// collects a set of signed values, sorts them ascending in a row of
// compare-exchange cells and streams them out with last and overflow flags
// ----------------------------------------------------------------------------
module odd_even_transposition_sort_unit
    import oets_pkg::*;
#(
    parameter int unsigned MAX_ITEMS = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [DATA_W-1:0]  s_item_value,
    input  logic                      s_is_last,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [DATA_W-1:0]  m_sorted_value,
    output logic                      m_end_of_set,
    output logic                      m_overflowed
);

    localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_SORT  = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   phase_reg, phase_next;
    logic            overflow_reg, overflow_next;
    cell_ctrl_t      ctrl;

    logic signed [DATA_W-1:0] cell_data [MAX_ITEMS];
    logic [MAX_ITEMS-1:0]     occ_vec;
    logic [MAX_ITEMS-1:0]     gt_vec;

    logic in_fire;
    logic out_fire;
    logic has_room;

    assign s_ready  = (state_reg == ST_LOAD);
    assign m_valid  = (state_reg == ST_DRAIN) && occ_vec[0];
    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid && m_ready;
    assign has_room = (count_reg < CW'(MAX_ITEMS));

    assign m_sorted_value = cell_data[0];
    assign m_end_of_set   = !occ_vec[1];
    assign m_overflowed   = overflow_reg;

    always_comb begin
        ctrl.phase = phase_reg[0];
        ctrl.op    = CELL_HOLD;
        case (state_reg)
            ST_LOAD: begin
                if (in_fire && has_room) begin
                    ctrl.op = CELL_LOAD;
                end
            end
            ST_SORT: begin
                ctrl.op = CELL_SORT;
            end
            ST_DRAIN: begin
                if (out_fire) begin
                    ctrl.op = CELL_DRAIN;
                end
            end
            default: begin
                ctrl.op = CELL_HOLD;
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        phase_next    = phase_reg;
        overflow_next = overflow_reg;
        case (state_reg)
            ST_LOAD: begin
                if (in_fire) begin
                    if (has_room) begin
                        count_next = count_reg + 1'b1;
                    end else begin
                        overflow_next = 1'b1;
                    end
                    if (s_is_last) begin
                        state_next = ST_SORT;
                        phase_next = '0;
                    end
                end
            end
            ST_SORT: begin
                phase_next = phase_reg + 1'b1;
                if (phase_reg == CW'(count_reg - 1'b1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (out_fire && !occ_vec[1]) begin
                    state_next    = ST_LOAD;
                    count_next    = '0;
                    overflow_next = 1'b0;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            phase_reg    <= '0;
            overflow_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            phase_reg    <= phase_next;
            overflow_reg <= overflow_next;
        end
    end

    for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
        logic signed [DATA_W-1:0] left_data;
        logic                     left_occ;
        logic                     left_gt;
        logic signed [DATA_W-1:0] right_data;
        logic                     right_occ;

        if (i == 0) begin : g_first
            assign left_data = s_item_value;
            assign left_occ  = 1'b1;
            assign left_gt   = 1'b0;
        end else begin : g_inner_left
            assign left_data = cell_data[i-1];
            assign left_occ  = occ_vec[i-1];
            assign left_gt   = gt_vec[i-1];
        end

        if (i == MAX_ITEMS - 1) begin : g_last
            assign right_data = '0;
            assign right_occ  = 1'b0;
        end else begin : g_inner_right
            assign right_data = cell_data[i+1];
            assign right_occ  = occ_vec[i+1];
        end

        oets_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .cell_odd   (1'(i % 2)),
            .left_data  (left_data),
            .left_occ   (left_occ),
            .left_gt    (left_gt),
            .right_data (right_data),
            .right_occ  (right_occ),
            .data_out   (cell_data[i]),
            .occ_out    (occ_vec[i]),
            .gt_out     (gt_vec[i])
        );
    end

    // outside drain, the number of occupied cells matches the kept count
    a_occ_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_DRAIN) |-> ($countones(occ_vec) == count_reg))
        else $error("cell occupancy disagrees with element count");

    a_sort_keeps_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SORT) |=> $stable(occ_vec))
        else $error("occupancy changed during sort phase");

    a_drain_has_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |-> occ_vec[0])
        else $error("drain state with empty head cell");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and output sides active together");

endmodule

[hw/rtl/oets_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oets_cell
// one storage cell of the sorting row: shifts in on load, compare-exchanges
// with a neighbor on sort phases, shifts toward the output on drain
// ----------------------------------------------------------------------------
module oets_cell
    import oets_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cell_ctrl_t                ctrl,
    input  logic                      cell_odd,
    input  logic signed [DATA_W-1:0]  left_data,
    input  logic                      left_occ,
    input  logic                      left_gt,
    input  logic signed [DATA_W-1:0]  right_data,
    input  logic                      right_occ,
    output logic signed [DATA_W-1:0]  data_out,
    output logic                      occ_out,
    output logic                      gt_out
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     occ_reg;
    logic                     occ_next;
    logic                     lower;

    assign lower  = (cell_odd == ctrl.phase);
    assign gt_out = occ_reg && right_occ && (data_reg > right_data);

    always_comb begin
        data_next = data_reg;
        occ_next  = occ_reg;
        case (ctrl.op)
            CELL_LOAD: begin
                data_next = left_data;
                occ_next  = left_occ;
            end
            CELL_DRAIN: begin
                data_next = right_data;
                occ_next  = right_occ;
            end
            CELL_SORT: begin
                if (lower && gt_out) begin
                    data_next = right_data;
                end else if (!lower && left_gt) begin
                    data_next = left_data;
                end
            end
            default: begin
                data_next = data_reg;
                occ_next  = occ_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    assign data_out = data_reg;
    assign occ_out  = occ_reg;

endmodule

[tb/odd_even_transposition_sort_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odd_even_transposition_sort_unit_tb
// streams sets of signed values into the sorter and checks every sorted
// transaction against an in-bench odd-even transposition model: value order,
// end-of-set flag and overflow flag, under several sender/receiver idle
// patterns, a long receiver hold-off and full and overflowing sets
// ----------------------------------------------------------------------------
module odd_even_transposition_sort_unit_tb;
    import oets_pkg::*;

    localparam int STORE_DEPTH    = 64;
    localparam int IDLE_PCT_HEAVY = 83;
    localparam int IDLE_PCT_LIGHT = 8;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 200;
    localparam int DIRECTED_COUNT = 23;

    typedef enum logic [1:0] {
        IDLE_NONE = 2'd0,
        IDLE_SEND = 2'd1,
        IDLE_RECV = 2'd2,
        IDLE_BOTH = 2'd3
    } idle_mode_t;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        idle_mode_t               mode;
        logic                     drain_first;
        logic                     hold;
    } load_item_t;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     end_of_set;
        logic                     overflowed;
    } sorted_result_t;

    // extremes, equal values, single-element sets, reversed and ordered input
    localparam logic signed [DATA_W-1:0] DIRECTED_VALUES [DIRECTED_COUNT] = '{
        32'sh7FFF_FFFF,
        32'sh8000_0000,
        5, -3, 5, 32'sh8000_0000, 32'sh7FFF_FFFF, -1, 0, 5, -3,
        6, 5, 4, 3, 2, 1,
        -20, -10, 10, 20,
        7, 7
    };
    localparam logic DIRECTED_LAST [DIRECTED_COUNT] = '{
        1'b1,
        1'b1,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
        1'b0, 1'b0, 1'b0, 1'b1,
        1'b0, 1'b1
    };

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic signed [DATA_W-1:0] s_item_value = '0;
    logic                     s_is_last = 1'b0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [DATA_W-1:0] m_sorted_value;
    logic                     m_end_of_set;
    logic                     m_overflowed;

    load_item_t               pending_loads [$];
    sorted_result_t           expected_sorted [$];
    logic signed [DATA_W-1:0] kept_values [$];
    logic                     set_dropped = 1'b0;
    int                       outstanding = 0;
    int                       errors = 0;
    idle_mode_t               cur_mode = IDLE_NONE;
    logic                     hold_req = 1'b0;
    int                       hold_left = 0;
    int                       quiet_cycles = 0;

    odd_even_transposition_sort_unit #(
        .MAX_ITEMS(STORE_DEPTH)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_item_value  (s_item_value),
        .s_is_last     (s_is_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sorted_value(m_sorted_value),
        .m_end_of_set  (m_end_of_set),
        .m_overflowed  (m_overflowed)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
    end

    task automatic add_random_set(input int size, input idle_mode_t mode,
                                  input logic drain_first, input logic hold);
        load_item_t item;
        for (int i = 0; i < size; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                item.value = $signed($urandom_range(0, 4)) - 2;
            end else begin
                item.value = $urandom;
            end
            item.last        = (i == size - 1);
            item.mode        = mode;
            item.drain_first = drain_first && (i == 0);
            item.hold        = hold && (i == 0);
            pending_loads.push_back(item);
        end
    endtask

    task automatic add_random_phase(input idle_mode_t mode, input int quota);
        int count;
        int size;
        count = 0;
        while (count < quota) begin
            size = $urandom_range(1, 8);
            add_random_set(size, mode, count == 0, 1'b0);
            count += size;
        end
    endtask

    // store the value, and on the closing transaction sort and queue the set
    task automatic absorb_value(input logic signed [DATA_W-1:0] value, input logic last);
        logic signed [DATA_W-1:0] row [$];
        logic signed [DATA_W-1:0] swap;
        sorted_result_t           entry;
        int                       n;
        if (kept_values.size() < STORE_DEPTH) begin
            kept_values.push_back(value);
        end else begin
            set_dropped = 1'b1;
        end
        if (last) begin
            row = kept_values;
            n   = row.size();
            for (int ph = 0; ph < n; ph++) begin
                for (int j = ph % 2; j + 1 < n; j += 2) begin
                    if (row[j] > row[j+1]) begin
                        swap     = row[j];
                        row[j]   = row[j+1];
                        row[j+1] = swap;
                    end
                end
            end
            for (int k = 0; k < n; k++) begin
                entry.value      = row[k];
                entry.end_of_set = (k == n - 1);
                entry.overflowed = set_dropped;
                expected_sorted.push_back(entry);
            end
            kept_values.delete();
            set_dropped = 1'b0;
        end
    endtask

    initial begin : stimulus
        load_item_t item;
        for (int i = 0; i < DIRECTED_COUNT; i++) begin
            item.value       = DIRECTED_VALUES[i];
            item.last        = DIRECTED_LAST[i];
            item.mode        = IDLE_NONE;
            item.drain_first = 1'b0;
            item.hold        = 1'b0;
            pending_loads.push_back(item);
        end
        // full store, then a set offered while the receiver holds off, then overflow
        add_random_set(STORE_DEPTH, IDLE_NONE, 1'b1, 1'b0);
        add_random_set($urandom_range(2, 6), IDLE_NONE, 1'b0, 1'b1);
        add_random_set(STORE_DEPTH + $urandom_range(1, 3), IDLE_NONE, 1'b1, 1'b0);
        add_random_phase(IDLE_NONE, 10);
        add_random_phase(IDLE_SEND, 12);
        add_random_phase(IDLE_RECV, 12);
        add_random_phase(IDLE_BOTH, 12);

        do begin
            @(negedge aclk);
        end while (!(aresetn && pending_loads.size() == 0 && !s_valid && outstanding == 0));
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    always @(posedge aclk) begin : driver
        load_item_t next_item;
        logic       hold_next;
        int         idle_pct;
        logic       may_offer;
        hold_next = 1'b0;
        if (!aresetn) begin
            s_valid      <= 1'b0;
            s_item_value <= '0;
            s_is_last    <= 1'b0;
        end else if (!s_valid || s_ready) begin
            may_offer = 1'b0;
            if (pending_loads.size() > 0) begin
                idle_pct = (pending_loads[0].mode == IDLE_SEND) ? IDLE_PCT_HEAVY :
                           (pending_loads[0].mode == IDLE_BOTH) ? IDLE_PCT_LIGHT : 0;
                may_offer = ($urandom_range(0, 99) >= idle_pct) &&
                            (!pending_loads[0].drain_first || (outstanding == 0 && !s_valid));
            end
            if (may_offer) begin
                next_item    = pending_loads.pop_front();
                s_valid      <= 1'b1;
                s_item_value <= next_item.value;
                s_is_last    <= next_item.last;
                cur_mode     <= next_item.mode;
                hold_next    = next_item.hold;
            end else begin
                s_valid <= 1'b0;
            end
        end
        hold_req <= hold_next;
    end

    always @(posedge aclk) begin : receiver
        int stall_pct;
        stall_pct = (cur_mode == IDLE_RECV) ? IDLE_PCT_HEAVY :
                    (cur_mode == IDLE_BOTH) ? IDLE_PCT_LIGHT : 0;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else if (hold_req) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin : monitor
        sorted_result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                absorb_value(s_item_value, s_is_last);
            end
            if (m_valid && m_ready) begin
                if (expected_sorted.size() == 0) begin
                    errors++;
                    $display({"%0t: unexpected transaction, expected none, ",
                              "actual value %0d end %0b ovf %0b"},
                             $realtime, m_sorted_value, m_end_of_set, m_overflowed);
                end else begin
                    want = expected_sorted.pop_front();
                    if (m_sorted_value !== want.value) begin
                        errors++;
                        $display("%0t: sorted_value mismatch, expected %0d actual %0d",
                                 $realtime, want.value, m_sorted_value);
                    end
                    if (m_end_of_set !== want.end_of_set) begin
                        errors++;
                        $display("%0t: end_of_set mismatch, expected %0b actual %0b",
                                 $realtime, want.end_of_set, m_end_of_set);
                    end
                    if (m_overflowed !== want.overflowed) begin
                        errors++;
                        $display("%0t: overflowed mismatch, expected %0b actual %0b",
                                 $realtime, want.overflowed, m_overflowed);
                    end
                end
            end
            outstanding <= expected_sorted.size();
        end
    end

    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
